// ----- design/btsg_pkg.sv -----
// Shared types, constants and arithmetic helpers for the bilinear texture unit.
// No dependencies.
package btsg_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int CHANNELS   = 3;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int AW         = XW + YW;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int SW         = 7;      // size register width
    localparam int TW         = 24;     // texel channel width
    localparam int GW         = 32;     // gradient channel width
    localparam int QW         = 17;     // Q1.16 coordinate / fraction width
    localparam int WW         = 33;     // Q1.32 weight width
    localparam int PW         = 60;     // product / accumulator width
    localparam int QDEPTH     = 2;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE  = 2'd1;
    localparam logic [1:0] CMD_SCATTER = 2'd2;
    localparam logic [1:0] CMD_GREAD   = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [QW-1:0] ONE_Q16 = 17'h10000;

    typedef struct packed {
        logic [1:0]                      cmd;
        logic [XW-1:0]                   x0;
        logic [XW-1:0]                   x1;
        logic [YW-1:0]                   y0;
        logic [YW-1:0]                   y1;
        logic [QW-1:0]                   fx;
        logic [QW-1:0]                   fy;
        logic [CHANNELS-1:0][TW-1:0]     val;
    } item_t;

    // round half up of x / 2^32
    function automatic logic signed [PW-1:0] rnd_q32(input logic signed [PW-1:0] x);
        logic signed [PW-1:0] t;
        begin
            t = x + PW'(64'h8000_0000);
            rnd_q32 = t >>> 32;
        end
    endfunction

    function automatic logic [GW-1:0] sat32(input logic signed [PW-1:0] x);
        begin
            if (x > PW'(64'sh7FFF_FFFF))
                sat32 = 32'h7FFF_FFFF;
            else if (x < -PW'(64'sh8000_0000))
                sat32 = 32'h8000_0000;
            else
                sat32 = x[GW-1:0];
        end
    endfunction

endpackage

// ----- design/bilinear_texture_sample_with_grad.sv -----
// Top level: bilinear texture sample / gradient scatter unit.
// The back end handles one request at a time, walking the four corners of a sample or
// scatter one by one through the single-ported stores; the 2-entry front queue can take
// further requests meanwhile. After reset a clearing pass zeroes the gradient store;
// no request is taken until it ends. Size registers reset to 64.
module bilinear_texture_sample_with_grad import btsg_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_index,
    input  logic [SW-1:0]         cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  logic [XW-1:0]         texel_x,
    input  logic [YW-1:0]         texel_y,
    input  logic [QW-1:0]         coord_u,
    input  logic [QW-1:0]         coord_v,
    input  logic signed [TW-1:0]  value_r,
    input  logic signed [TW-1:0]  value_g,
    input  logic signed [TW-1:0]  value_b,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [GW-1:0]  out_r,
    output logic signed [GW-1:0]  out_g,
    output logic signed [GW-1:0]  out_b
);

    logic                         enable, q_valid, q_pop;
    item_t                        q_item;
    logic                         tex_en, tex_we, grd_en, grd_we;
    logic [AW-1:0]                tex_addr, grd_addr;
    logic [CHANNELS*TW-1:0]       tex_wdata, tex_rdata;
    logic [CHANNELS*GW-1:0]       grd_wdata, grd_rdata;
    logic [CHANNELS-1:0][GW-1:0]  res;
    logic [CHANNELS-1:0][TW-1:0]  vals;

    assign vals  = {value_b, value_g, value_r};
    assign out_r = res[0];
    assign out_g = res[1];
    assign out_b = res[2];

    btsg_front u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_valid, .in_ready, .cmd, .texel_x, .texel_y, .coord_u, .coord_v,
        .vals, .enable, .q_valid, .q_pop, .q_item
    );

    btsg_back u_back (
        .clk, .rst_n, .ready_for_work(enable), .q_valid, .q_pop, .q_item,
        .tex_en, .tex_we, .tex_addr, .tex_wdata, .tex_rdata,
        .grd_en, .grd_we, .grd_addr, .grd_wdata, .grd_rdata,
        .out_valid, .out_ready, .res
    );

    btsg_ram #(.WIDTH(CHANNELS*TW), .DEPTH(DEPTH)) u_tex_ram (
        .clk, .en(tex_en), .we(tex_we), .addr(tex_addr),
        .wdata(tex_wdata), .rdata(tex_rdata)
    );

    btsg_ram #(.WIDTH(CHANNELS*GW), .DEPTH(DEPTH)) u_grd_ram (
        .clk, .en(grd_en), .we(grd_we), .addr(grd_addr),
        .wdata(grd_wdata), .rdata(grd_rdata)
    );

endmodule

// ----- design/btsg_ram.sv -----
// Generic single-port RAM with registered read (data held when not enabled).
// No dependencies.
module btsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            rdata <= mem[addr];
        end
    end

endmodule

// ----- design/btsg_front.sv -----
// Front end: size registers, request accept, corner/fraction setup, 2-entry queue.
// Depends on btsg_pkg.
module btsg_front import btsg_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [7:0]                  cfg_index,
    input  logic [SW-1:0]               cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic [XW-1:0]               texel_x,
    input  logic [YW-1:0]               texel_y,
    input  logic [QW-1:0]               coord_u,
    input  logic [QW-1:0]               coord_v,
    input  logic [CHANNELS-1:0][TW-1:0] vals,
    input  logic                        enable,
    output logic                        q_valid,
    input  logic                        q_pop,
    output item_t                       q_item
);

    logic [SW-1:0] width_reg, height_reg;
    item_t         q_reg [QDEPTH];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;
    item_t         item;
    logic          push;

    function automatic logic [SW-1:0] eff(input logic [SW-1:0] r, input int mx);
        begin
            if (r == '0)
                eff = SW'(1);
            else if (r > SW'(mx))
                eff = SW'(mx);
            else
                eff = r;
        end
    endfunction

    // corner clamp and fraction for one axis
    function automatic logic [XW+QW-1:0] axis(input logic [QW-1:0] coord,
                                              input logic [SW-1:0] size);
        logic [QW-1:0]    c;
        logic [QW+SW-1:0] px;
        logic [SW:0]      ix;
        logic [SW-1:0]    c0;
        logic [QW+SW-1:0] f;
        begin
            c  = (coord > ONE_Q16) ? ONE_Q16 : coord;
            px = c * size;
            ix = px[QW+SW-1:16];
            c0 = (ix < {1'b0, size - 1'b1}) ? ix[SW-1:0] : size - 1'b1;
            f  = px - {c0, 16'h0};
            axis = {c0[XW-1:0], f[QW-1:0]};
        end
    endfunction

    function automatic logic [XW-1:0] upper(input logic [XW-1:0] c0,
                                            input logic [SW-1:0] size);
        logic [SW-1:0] n;
        begin
            n = {1'b0, c0} + 1'b1;
            upper = (n < size - 1'b1) ? n[XW-1:0] : XW'(size - 1'b1);
        end
    endfunction

    logic [SW-1:0]       w_eff, h_eff;
    logic [XW+QW-1:0]    ax, ay;

    always_comb
    begin
        w_eff    = eff(width_reg, MAX_WIDTH);
        h_eff    = eff(height_reg, MAX_HEIGHT);
        ax       = axis(coord_u, w_eff);
        ay       = axis(coord_v, h_eff);
        item.cmd = cmd;
        item.val = vals;
        item.fx  = ax[QW-1:0];
        item.fy  = ay[QW-1:0];
        if (cmd == CMD_WRITE || cmd == CMD_GREAD)
        begin
            item.x0 = texel_x;
            item.x1 = texel_x;
            item.y0 = texel_y;
            item.y1 = texel_y;
        end
        else
        begin
            item.x0 = ax[XW+QW-1:QW];
            item.y0 = ay[YW+QW-1:QW];
            item.x1 = upper(ax[XW+QW-1:QW], w_eff);
            item.y1 = upper(ay[YW+QW-1:QW], h_eff);
        end
    end

    assign in_ready = enable && (cnt_reg != 2'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SW'(MAX_WIDTH);
            height_reg <= SW'(MAX_HEIGHT);
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index[7:1] == '0)
            begin
                if (cfg_index[0] == REG_WIDTH)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
            end
            if (push)
            begin
                q_reg[wr_ptr_reg] <= item;
                wr_ptr_reg        <= ~wr_ptr_reg;
            end
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

// ----- design/btsg_back.sv -----
// Back end: clear pass, texel write, gradient read, per-corner read / multiply / accumulate or read-modify-write.
// Depends on btsg_pkg; drives the two store RAMs.
module btsg_back import btsg_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    output logic                        ready_for_work,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  item_t                       q_item,
    output logic                        tex_en,
    output logic                        tex_we,
    output logic [AW-1:0]               tex_addr,
    output logic [CHANNELS*TW-1:0]      tex_wdata,
    input  logic [CHANNELS*TW-1:0]      tex_rdata,
    output logic                        grd_en,
    output logic                        grd_we,
    output logic [AW-1:0]               grd_addr,
    output logic [CHANNELS*GW-1:0]      grd_wdata,
    input  logic [CHANNELS*GW-1:0]      grd_rdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [CHANNELS-1:0][GW-1:0] res
);

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_WR, S_GRD, S_GRD2, S_RD, S_MUL, S_ACC}
        state_t;

    state_t                       state_reg;
    logic [AW-1:0]                clr_reg;
    item_t                        it_reg;
    logic [1:0]                   k_reg;
    logic [WW-1:0]                wt_reg;
    logic signed [PW-1:0]         prod_reg [CHANNELS];
    logic signed [PW-1:0]         acc_reg  [CHANNELS];
    logic [CHANNELS-1:0][GW-1:0]  res_reg;
    logic                         done_reg;
    logic                         out_valid_reg;

    logic [AW-1:0]                corner;
    logic [QW-1:0]                wa, wb;
    logic                         out_free;
    logic                         load_out;

    assign out_free       = !out_valid_reg || out_ready;
    assign load_out       = (state_reg == S_IDLE) && done_reg && out_free;
    assign out_valid      = out_valid_reg;
    assign ready_for_work = (state_reg != S_CLR);
    assign q_pop          = (state_reg == S_IDLE) && !done_reg && q_valid;

    always_comb
    begin
        unique case (k_reg)
            2'd0: corner = {it_reg.y0, it_reg.x0};
            2'd1: corner = {it_reg.y1, it_reg.x0};
            2'd2: corner = {it_reg.y0, it_reg.x1};
            default: corner = {it_reg.y1, it_reg.x1};
        endcase
        wa = k_reg[1] ? it_reg.fx : ONE_Q16 - it_reg.fx;
        wb = k_reg[0] ? it_reg.fy : ONE_Q16 - it_reg.fy;

        tex_en    = 1'b0;
        tex_we    = 1'b0;
        tex_addr  = corner;
        tex_wdata = it_reg.val;
        grd_en    = 1'b0;
        grd_we    = 1'b0;
        grd_addr  = corner;
        grd_wdata = '0;
        unique case (state_reg)
            S_CLR:
            begin
                grd_en   = 1'b1;
                grd_we   = 1'b1;
                grd_addr = clr_reg;
            end
            S_WR:
            begin
                tex_en = 1'b1;
                tex_we = 1'b1;
            end
            S_GRD:
                grd_en = 1'b1;
            S_RD:
            begin
                tex_en = (it_reg.cmd == CMD_SAMPLE);
                grd_en = (it_reg.cmd == CMD_SCATTER);
            end
            S_ACC:
            begin
                if (it_reg.cmd == CMD_SCATTER)
                begin
                    grd_en = 1'b1;
                    grd_we = 1'b1;
                    for (int c = 0; c < CHANNELS; c++)
                        grd_wdata[c*GW +: GW] = sat32(
                            PW'($signed(grd_rdata[c*GW +: GW])) + rnd_q32(prod_reg[c]));
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            k_reg         <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= load_out || (out_valid_reg && !out_ready);
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (done_reg)
                    begin
                        if (out_free)
                        begin
                            res      <= res_reg;
                            done_reg <= 1'b0;
                        end
                    end
                    else if (q_valid)
                    begin
                        it_reg  <= q_item;
                        k_reg   <= '0;
                        res_reg <= '0;
                        for (int c = 0; c < CHANNELS; c++)
                            acc_reg[c] <= '0;
                        unique case (q_item.cmd)
                            CMD_WRITE:   state_reg <= S_WR;
                            CMD_GREAD:   state_reg <= S_GRD;
                            default:     state_reg <= S_RD;
                        endcase
                    end
                end
                S_WR:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_GRD:
                    state_reg <= S_GRD2;
                S_GRD2:
                begin
                    res_reg   <= grd_rdata;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_RD:
                begin
                    wt_reg    <= WW'(wa * wb);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    for (int c = 0; c < CHANNELS; c++)
                        if (it_reg.cmd == CMD_SAMPLE)
                            prod_reg[c] <= PW'($signed({1'b0, wt_reg})
                                               * $signed(tex_rdata[c*TW +: TW]));
                        else
                            prod_reg[c] <= PW'($signed({1'b0, wt_reg})
                                               * $signed(it_reg.val[c]));
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        acc_reg[c] <= acc_reg[c] + prod_reg[c];
                        if (it_reg.cmd == CMD_SAMPLE)
                            res_reg[c] <= sat32(rnd_q32(acc_reg[c] + prod_reg[c]));
                    end
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 2'd3)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_RD;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !q_pop && !tex_we)
        else $error("request taken during clear pass");
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC && k_reg == 2'd3 |=> state_reg == S_IDLE && done_reg)
        else $error("corner sequence did not finish");
    a_no_pop_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !q_pop)
        else $error("new request started with result pending");

endmodule
